// ===== hw/rtl/rpn_pkg.sv =====
// Package for the RPN stack calculator core: sizes, codes, types.
// No dependencies.
package rpn_pkg;
    localparam int StackDepth = 64;
    localparam int AddrW      = $clog2(StackDepth);
    localparam int CountW     = $clog2(StackDepth + 1);

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
        OP_DIV  = 3'd4, OP_SWAP = 3'd5, OP_DUP = 3'd6, OP_PEEK = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_OVERFLOW = 3'd2, ST_DIVZERO = 3'd3,
        ST_FULL = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_A, S_RD_B, S_WAIT, S_EXEC, S_DIV, S_WR1, S_WR2, S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;     // capture input word
        logic rd_a;        // address top
        logic rd_b;        // address top-1 (or peek)
        logic cap_a;
        logic cap_b;
        logic exec;        // compute result / status
        logic div_start;
        logic div_step;
        logic div_end;
        logic wr1;         // write first word
        logic wr2;         // write second word (swap)
        logic done;        // present result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       need_a;
        logic       need_b;
        logic       do_div;
        logic       wr1_ok;
        logic       wr2_ok;
        logic       div_last;
    } stat_t;
endpackage

// ===== hw/rtl/rpn_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rpn_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/rpn_ctrl.sv =====
// Controller state machine for the RPN stack core.
// Depends on rpn_pkg.
module rpn_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rpn_pkg::stat_t st,
    output rpn_pkg::cmd_t  cmd
);
    rpn_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= rpn_pkg::S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rpn_pkg::S_IDLE: if (in_valid) state_next = rpn_pkg::S_RD_A;
            rpn_pkg::S_RD_A: state_next = rpn_pkg::S_RD_B;
            rpn_pkg::S_RD_B: state_next = rpn_pkg::S_WAIT;
            rpn_pkg::S_WAIT: state_next = rpn_pkg::S_EXEC;
            rpn_pkg::S_EXEC: state_next = st.do_div ? rpn_pkg::S_DIV : rpn_pkg::S_WR1;
            rpn_pkg::S_DIV:  if (st.div_last) state_next = rpn_pkg::S_WR1;
            rpn_pkg::S_WR1:  state_next = rpn_pkg::S_WR2;
            rpn_pkg::S_WR2:  state_next = rpn_pkg::S_DONE;
            rpn_pkg::S_DONE: if (out_ready) state_next = rpn_pkg::S_IDLE;
            default:         state_next = rpn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            rpn_pkg::S_IDLE: begin
                in_ready     = 1'b1;
                cmd.load_in  = in_valid;
            end
            rpn_pkg::S_RD_A: cmd.rd_a = 1'b1;
            rpn_pkg::S_RD_B: begin
                cmd.rd_b  = 1'b1;
                cmd.cap_a = 1'b1;
            end
            rpn_pkg::S_WAIT: cmd.cap_b = 1'b1;
            rpn_pkg::S_EXEC: begin
                cmd.exec      = 1'b1;
                cmd.div_start = st.do_div;
            end
            rpn_pkg::S_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_end  = st.div_last;
            end
            rpn_pkg::S_WR1:  cmd.wr1 = st.wr1_ok;
            rpn_pkg::S_WR2:  cmd.wr2 = st.wr2_ok;
            rpn_pkg::S_DONE: begin
                out_valid = 1'b1;
                cmd.done  = out_ready;
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/rpn_dp.sv =====
// Datapath: stack RAM, stack pointer, add/sub, combinational multiply,
// bit-serial restoring divider. Depends on rpn_pkg and rpn_ram.
module rpn_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rpn_pkg::cmd_t        cmd,
    output rpn_pkg::stat_t       st,
    input  logic [2:0]           in_op,
    input  logic signed [31:0]   in_value,
    input  logic [5:0]           in_depth,
    output logic [2:0]           out_status,
    output logic signed [31:0]   out_value
);
    localparam int AW = rpn_pkg::AddrW;
    localparam int CW = rpn_pkg::CountW;

    logic [2:0]  op_reg;
    logic [31:0] pv_reg;
    logic [5:0]  dep_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0] a_reg, b_reg, res_reg, w2_reg;
    logic [2:0]  status_reg;
    logic        wr1_reg, wr2_reg;
    logic [AW-1:0] raddr;
    logic [31:0] rdata;
    logic        we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;

    // divider
    logic [31:0] q_reg, dv_reg;
    logic [32:0] r_reg;
    logic [4:0]  dcnt_reg;
    logic        qneg_reg, rneg_unused;
    logic [32:0] rtrial;

    assign rneg_unused = 1'b0;

    rpn_ram #(.Width(32), .Depth(rpn_pkg::StackDepth)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [CW-1:0] top1, top2, dptr;
    assign top1 = cnt_reg - CW'(1);
    assign top2 = cnt_reg - CW'(2);
    assign dptr = cnt_reg - CW'(1) - CW'(dep_reg);

    always_comb begin
        raddr = top1[AW-1:0];
        if (cmd.rd_b) raddr = (op_reg == rpn_pkg::OP_PEEK) ? dptr[AW-1:0] : top2[AW-1:0];
    end

    logic binop;
    assign binop = (op_reg >= rpn_pkg::OP_ADD) && (op_reg <= rpn_pkg::OP_SWAP);

    assign st.op       = op_reg;
    assign st.need_a   = 1'b1;
    assign st.need_b   = binop;
    assign st.do_div   = (op_reg == rpn_pkg::OP_DIV) && (cnt_reg >= CW'(2))
                         && (a_reg != 32'd0)
                         && !(b_reg == 32'h8000_0000 && a_reg == 32'hFFFF_FFFF);
    assign st.wr1_ok   = wr1_reg;
    assign st.wr2_ok   = wr2_reg;
    assign st.div_last = (dcnt_reg == 5'd31);

    // write port: wr1 at cnt, wr2 at cnt (after first increment)
    assign we    = cmd.wr1 | cmd.wr2;
    assign waddr = cnt_reg[AW-1:0];
    assign wdata = cmd.wr2 ? w2_reg : res_reg;

    logic signed [32:0] sum, dif;
    logic signed [63:0] prod;
    assign sum  = $signed({a_reg[31], a_reg}) + $signed({b_reg[31], b_reg});
    assign dif  = $signed({b_reg[31], b_reg}) - $signed({a_reg[31], a_reg});
    assign prod = $signed(b_reg) * $signed(a_reg);

    assign rtrial = {r_reg[31:0], q_reg[31]} - {1'b0, dv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        if (cmd.load_in) begin
            op_reg  <= in_op;
            pv_reg  <= in_value;
            dep_reg <= in_depth;
        end
        if (cmd.cap_a) a_reg <= rdata;
        if (cmd.cap_b) b_reg <= rdata;
        if (cmd.exec) begin
            wr1_reg    <= 1'b0;
            wr2_reg    <= 1'b0;
            status_reg <= rpn_pkg::ST_OK;
            res_reg    <= 32'd0;
            case (op_reg)
                rpn_pkg::OP_PUSH: begin
                    if (cnt_reg >= CW'(rpn_pkg::StackDepth)) status_reg <= rpn_pkg::ST_FULL;
                    else begin
                        res_reg <= pv_reg;
                        wr1_reg <= 1'b1;
                    end
                end
                rpn_pkg::OP_DUP: begin
                    if (cnt_reg == '0) status_reg <= rpn_pkg::ST_EMPTY;
                    else if (cnt_reg >= CW'(rpn_pkg::StackDepth))
                        status_reg <= rpn_pkg::ST_FULL;
                    else begin
                        res_reg <= a_reg;
                        wr1_reg <= 1'b1;
                    end
                end
                rpn_pkg::OP_PEEK: begin
                    if (CW'(dep_reg) >= cnt_reg) status_reg <= rpn_pkg::ST_EMPTY;
                    else res_reg <= b_reg;
                end
                default: begin
                    if (cnt_reg < CW'(2)) status_reg <= rpn_pkg::ST_EMPTY;
                    else begin
                        case (op_reg)
                            rpn_pkg::OP_ADD:
                                if (sum[32] != sum[31]) status_reg <= rpn_pkg::ST_OVERFLOW;
                                else begin res_reg <= sum[31:0]; wr1_reg <= 1'b1; end
                            rpn_pkg::OP_SUB:
                                if (dif[32] != dif[31]) status_reg <= rpn_pkg::ST_OVERFLOW;
                                else begin res_reg <= dif[31:0]; wr1_reg <= 1'b1; end
                            rpn_pkg::OP_MUL:
                                if (prod[63:31] != {33{prod[31]}})
                                    status_reg <= rpn_pkg::ST_OVERFLOW;
                                else begin res_reg <= prod[31:0]; wr1_reg <= 1'b1; end
                            rpn_pkg::OP_DIV:
                                if (a_reg == 32'd0) status_reg <= rpn_pkg::ST_DIVZERO;
                                else if (b_reg == 32'h8000_0000 && a_reg == 32'hFFFF_FFFF)
                                    status_reg <= rpn_pkg::ST_OVERFLOW;
                                else wr1_reg <= 1'b1;
                            default: begin // swap: push a then b, show b
                                res_reg <= a_reg;
                                w2_reg  <= b_reg;
                                wr1_reg <= 1'b1;
                                wr2_reg <= 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
        if (cmd.div_start) begin
            q_reg    <= b_reg[31] ? -b_reg : b_reg;
            dv_reg   <= a_reg[31] ? -a_reg : a_reg;
            r_reg    <= '0;
            dcnt_reg <= '0;
            qneg_reg <= b_reg[31] ^ a_reg[31];
        end
        if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 5'd1;
            if (!rtrial[32]) begin
                r_reg <= rtrial;
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                r_reg <= {r_reg[31:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
        if (cmd.div_end) begin
            // final quotient from this step's shifted bit
            res_reg <= qneg_reg ? -{q_reg[30:0], !rtrial[32]} : {q_reg[30:0], !rtrial[32]};
        end
        // swap: the new top is shown
        if (cmd.wr2) res_reg <= w2_reg;
    end

    // stack pointer
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.exec && binop) cnt_next = (cnt_reg < CW'(2)) ? '0 : top2;
        if (cmd.wr1 | cmd.wr2) cnt_next = cnt_reg + CW'(1);
        if (cmd.exec && rneg_unused) cnt_next = cnt_reg;
    end

    assign out_status = status_reg;
    assign out_value  = (status_reg == rpn_pkg::ST_OK) ? $signed(res_reg) : 32'sd0;
endmodule

// ===== hw/rtl/rpn_stack_alu_top.sv =====
// Channel  | dir | tdata fields (low bit up)             | tuser
// s_axis   | in  | push_value[31:0], peek_depth[37:32]   | operation[2:0]
// m_axis   | out | value[31:0]                           | status[2:0]
// One word at a time: read top, read next, execute, write, then hold the result until taken.
// Divide adds the 32-step bit-serial divider after execute; a faulting divide skips it.
// Reset (aresetn low, synchronous) empties the stack; RAM contents are not cleared.
// A stalled result holds m_axis until taken; no input is accepted meanwhile.
module rpn_stack_alu_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // push_value[31:0], peek_depth[37:32]
    input  logic [2:0]  s_axis_tuser,   // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [2:0]  m_axis_tuser    // status
);
    rpn_pkg::cmd_t  cmd;
    rpn_pkg::stat_t st;

    rpn_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .st(st), .cmd(cmd)
    );

    rpn_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st),
        .in_op(s_axis_tuser), .in_value(s_axis_tdata[31:0]),
        .in_depth(s_axis_tdata[37:32]),
        .out_status(m_axis_tuser), .out_value(m_axis_tdata)
    );
endmodule

// ===== hw/rtl/rpn_checker.sv =====
// Port-level checker for rpn_stack_alu_top, with its bind.
// Depends on rpn_pkg.
module rpn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != rpn_pkg::ST_OK |-> m_axis_tdata == 32'd0)
        else $error("nonzero value on error");
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= rpn_pkg::ST_FULL) else $error("bad status");
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
endmodule

bind rpn_stack_alu_top rpn_checker u_chk (.*);

// ===== tb/sv/tb_rpn_stack_alu_top.sv =====
// Testbench for rpn_stack_alu_top: directed table, fill to full, then random operation mix,
// every result checked against an in-bench stack calculator model.
// Depends on rpn_pkg and rpn_stack_alu_top.
module tb_rpn_stack_alu_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom = 860;
    localparam int CycleLimit = 400000;

    typedef struct {
        rpn_pkg::op_t     op;
        logic [31:0]      val;
        logic [5:0]       depth;
        bit               fixed;     // expected result typed in
        rpn_pkg::status_t st;
        logic [31:0]      res;
    } row_t;

    typedef struct {
        rpn_pkg::status_t st;
        logic [31:0]      res;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // push_value[31:0], peek_depth[37:32]
    logic [2:0]  s_axis_tuser = '0;     // operation[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // value
    logic [2:0]  m_axis_tuser;          // status

    rpn_stack_alu_top u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [31:0] calc_stack [rpn_pkg::StackDepth];
    int          calc_count;
    answer_t     pending_answers [$];
    int          fail_count;
    int          result_count;
    int          cycle_count;
    int          op_seen [8];
    int          status_seen [5];
    row_t        directed [$];

    // predictor: applies one operation to the model stack
    function automatic answer_t calc_apply(rpn_pkg::op_t op, logic [31:0] pv,
                                           logic [5:0] depth);
        answer_t     ans;
        longint      a, b, r;
        ans.st = rpn_pkg::ST_OK;
        ans.res = '0;
        r = 0;
        case (op)
            rpn_pkg::OP_PUSH: begin
                if (calc_count >= rpn_pkg::StackDepth) ans.st = rpn_pkg::ST_FULL;
                else begin
                    calc_stack[calc_count++] = pv;
                    ans.res = pv;
                end
            end
            rpn_pkg::OP_DUP: begin
                if (calc_count == 0) ans.st = rpn_pkg::ST_EMPTY;
                else if (calc_count >= rpn_pkg::StackDepth) ans.st = rpn_pkg::ST_FULL;
                else begin
                    calc_stack[calc_count] = calc_stack[calc_count-1];
                    ans.res = calc_stack[calc_count];
                    calc_count++;
                end
            end
            rpn_pkg::OP_PEEK: begin
                if (depth >= calc_count) ans.st = rpn_pkg::ST_EMPTY;
                else ans.res = calc_stack[calc_count-1-depth];
            end
            default: begin
                if (calc_count < 2) begin
                    calc_count = 0;
                    ans.st = rpn_pkg::ST_EMPTY;
                end else begin
                    a = longint'(signed'(calc_stack[calc_count-1]));
                    b = longint'(signed'(calc_stack[calc_count-2]));
                    calc_count -= 2;
                    case (op)
                        rpn_pkg::OP_ADD: r = b + a;
                        rpn_pkg::OP_SUB: r = b - a;
                        rpn_pkg::OP_MUL: r = b * a;
                        rpn_pkg::OP_DIV: begin
                            if (a == 0) ans.st = rpn_pkg::ST_DIVZERO;
                            else if (b == -64'sd2147483648 && a == -1)
                                ans.st = rpn_pkg::ST_OVERFLOW;
                            else r = b / a;
                        end
                        default: ;
                    endcase
                    if (op == rpn_pkg::OP_SWAP) begin
                        calc_stack[calc_count++] = a[31:0];
                        calc_stack[calc_count++] = b[31:0];
                        ans.res = b[31:0];
                    end else if (ans.st == rpn_pkg::ST_OK) begin
                        if (r > 64'sd2147483647 || r < -64'sd2147483648)
                            ans.st = rpn_pkg::ST_OVERFLOW;
                        else begin
                            calc_stack[calc_count++] = r[31:0];
                            ans.res = r[31:0];
                        end
                    end
                end
            end
        endcase
        return ans;
    endfunction

    // sender: bursts with random gaps; table row fixes expected if set
    task automatic send_word(rpn_pkg::op_t op, logic [31:0] pv, logic [5:0] depth,
                             bit fixed = 0, rpn_pkg::status_t st = rpn_pkg::ST_OK,
                             logic [31:0] res = '0);
        answer_t ans;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, depth, pv};
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        ans = calc_apply(op, pv, depth);
        op_seen[op]++;
        if (fixed && (ans.st != st || ans.res != res)) begin
            $display("%0t: table row disagrees with model: op %s exp %s/%0d got %s/%0d",
                     $time, op.name(), st.name(), $signed(res),
                     ans.st.name(), $signed(ans.res));
            fail_count++;
        end
        pending_answers.push_back(fixed ? answer_t'{st, res} : ans);
        if ($urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // receiver: stall pattern changes mode every so often
    always @(posedge aclk) begin
        int mode;
        if (cycle_count % 300 == 0) mode = $urandom_range(0, 2);
        case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        answer_t exp_ans;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected word status %0d value %0d",
                         $time, m_axis_tuser, $signed(m_axis_tdata));
                fail_count++;
            end else begin
                exp_ans = pending_answers.pop_front();
                if (m_axis_tuser < 5) status_seen[m_axis_tuser]++;
                if (m_axis_tuser != exp_ans.st) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_ans.st, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata != exp_ans.res) begin
                    $display("%0t: value exp %0d got %0d", $time,
                             $signed(exp_ans.res), $signed(m_axis_tdata));
                    fail_count++;
                end
            end
        end
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout, %0d words outstanding", $time, pending_answers.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom;
            5: return 32'(int'($urandom_range(0, 200)) - 100);
            6: return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    initial begin
        int           k;
        rpn_pkg::op_t op;
        logic [5:0]   d;
        calc_count = 0;
        cycle_count = 0;
        // after reset, extremes, error codes
        directed = '{
            '{rpn_pkg::OP_PEEK, 0, 6'd0, 1, rpn_pkg::ST_EMPTY, 0},
            '{rpn_pkg::OP_ADD,  0, 6'd0, 1, rpn_pkg::ST_EMPTY, 0},
            '{rpn_pkg::OP_DUP,  0, 6'd0, 1, rpn_pkg::ST_EMPTY, 0},
            '{rpn_pkg::OP_PUSH, 32'h7fff_ffff, 0, 1, rpn_pkg::ST_OK, 32'h7fff_ffff},
            '{rpn_pkg::OP_SWAP, 0, 6'd0, 1, rpn_pkg::ST_EMPTY, 0},
            '{rpn_pkg::OP_PUSH, 32'h7fff_ffff, 0, 1, rpn_pkg::ST_OK, 32'h7fff_ffff},
            '{rpn_pkg::OP_PUSH, 32'd1, 0, 1, rpn_pkg::ST_OK, 32'd1},
            '{rpn_pkg::OP_ADD,  0, 6'd0, 1, rpn_pkg::ST_OVERFLOW, 0},
            '{rpn_pkg::OP_PUSH, 32'h8000_0000, 0, 1, rpn_pkg::ST_OK, 32'h8000_0000},
            '{rpn_pkg::OP_PUSH, 32'hffff_ffff, 0, 1, rpn_pkg::ST_OK, 32'hffff_ffff},
            '{rpn_pkg::OP_DIV,  0, 6'd0, 1, rpn_pkg::ST_OVERFLOW, 0},
            '{rpn_pkg::OP_PUSH, 32'd7, 0, 1, rpn_pkg::ST_OK, 32'd7},
            '{rpn_pkg::OP_PUSH, 32'd0, 0, 1, rpn_pkg::ST_OK, 32'd0},
            '{rpn_pkg::OP_DIV,  0, 6'd0, 1, rpn_pkg::ST_DIVZERO, 0},
            '{rpn_pkg::OP_PUSH, 32'hffff_fff9, 0, 1, rpn_pkg::ST_OK, 32'hffff_fff9},
            '{rpn_pkg::OP_PUSH, 32'd2, 0, 1, rpn_pkg::ST_OK, 32'd2},
            '{rpn_pkg::OP_DIV,  0, 6'd0, 0, rpn_pkg::ST_OK, 0},
            '{rpn_pkg::OP_PUSH, 32'h8000_0000, 0, 0, rpn_pkg::ST_OK, 0},
            '{rpn_pkg::OP_SUB,  0, 6'd0, 0, rpn_pkg::ST_OK, 0},
            '{rpn_pkg::OP_PUSH, 32'h0001_0000, 0, 0, rpn_pkg::ST_OK, 0},
            '{rpn_pkg::OP_DUP,  0, 6'd0, 0, rpn_pkg::ST_OK, 0},
            '{rpn_pkg::OP_MUL,  0, 6'd0, 1, rpn_pkg::ST_OVERFLOW, 0},
            '{rpn_pkg::OP_PUSH, 32'h5a5a_5a5a, 0, 0, rpn_pkg::ST_OK, 0},
            '{rpn_pkg::OP_SWAP, 0, 6'd0, 0, rpn_pkg::ST_OK, 0},
            '{rpn_pkg::OP_PEEK, 0, 6'd63, 1, rpn_pkg::ST_EMPTY, 0}
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i])
            send_word(directed[i].op, directed[i].val, directed[i].depth,
                      directed[i].fixed, directed[i].st, directed[i].res);
        // fill to full for the full-stack cases and deepest peek
        while (calc_count < rpn_pkg::StackDepth) send_word(rpn_pkg::OP_PUSH, $urandom, 6'd0);
        send_word(rpn_pkg::OP_PUSH, 32'h1234_5678, 6'd0, 1, rpn_pkg::ST_FULL, 0);
        send_word(rpn_pkg::OP_DUP, 0, 6'd0, 1, rpn_pkg::ST_FULL, 0);
        send_word(rpn_pkg::OP_PEEK, 0, 6'd63, 0);
        // hold off until drained
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        for (k = 0; k < NumRandom; k++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5: op = rpn_pkg::OP_PUSH;
                6: op = rpn_pkg::OP_ADD;
                7: op = rpn_pkg::OP_SUB;
                8: op = rpn_pkg::OP_MUL;
                9, 10: op = rpn_pkg::OP_DIV;
                11: op = rpn_pkg::OP_SWAP;
                12: op = rpn_pkg::OP_DUP;
                default: op = rpn_pkg::OP_PEEK;
            endcase
            // keep depth mostly in range, sometimes beyond
            d = ($urandom_range(0, 3) == 0 || calc_count == 0) ? 6'($urandom)
                : 6'($urandom_range(0, calc_count - 1));
            send_word(op, pick_value(), d);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Covered %0d results: push %0d add %0d sub %0d mul %0d div %0d",
                 result_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
        $display("swap %0d dup %0d peek %0d; status ok/empty/ovf/div0/full %0d/%0d/%0d/%0d/%0d",
                 op_seen[5], op_seen[6], op_seen[7], status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3], status_seen[4]);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
